FILE: rtl/websocket_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication
`define WSFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfr implication check failed");

// Next-cycle implication
`define WSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfr next-cycle check failed");

`endif

FILE: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Parse phase codes, header constants and the result word layout.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Parse phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] OP_CLOSE    = 4'h8;

  // One result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic [3:0] msg_opcode;
    logic       is_control;
    logic       frame_done;
    logic       message_done;
    logic       close_seen;
    logic       masked_error;
  } result_t;

endpackage

FILE: rtl/wsfr_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver channels
// Valid/ready channels for received bytes and for parsed result words.
// ----------------------------------------------------------------------------

// Received byte channel
interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result word channel
interface wsfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic [3:0] frame_opcode;
  logic [3:0] msg_opcode;
  logic       is_control;
  logic       frame_done;
  logic       message_done;
  logic       close_seen;
  logic       masked_error;

  modport source (output valid, output payload_byte, output has_byte,
                  output frame_opcode, output msg_opcode, output is_control,
                  output frame_done, output message_done, output close_seen,
                  output masked_error, input ready);
  modport sink   (input valid, input payload_byte, input has_byte,
                  input frame_opcode, input msg_opcode, input is_control,
                  input frame_done, input message_done, input close_seen,
                  input masked_error, output ready);
endinterface

FILE: rtl/websocket_frame_receiver.sv
// A byte accepted into the input register is decoded from there into the result register.
// One byte per cycle unless the result channel stalls; the parse state and the 64-bit length
// counter update once per byte in one decode stage between input and result registers.
// Header bytes that complete nothing emit no result word, but for a masked-error word.
// Reset (rst_n low, synchronous) empties both stages and returns to the first header byte.
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Byte-serial parser of unmasked server-to-client frames with payload tagging.
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_assert.svh"

module websocket_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  wsfr_in_if.sink    in_ch,
  wsfr_out_if.source out_ch
);

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Parse state
  wsfr_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  cur_op_r, cur_op_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [3:0]  first_op_r, first_op_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        should_close_r, should_close_nxt;

  // Result stage
  logic              out_valid_r;
  wsfr_pkg::result_t out_data_r;
  wsfr_pkg::result_t res_nxt;
  logic              emit;

  logic out_free;
  logic in_ready;
  logic proc_go;

  // Handshake: result register frees when empty or taken
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || out_free;
  assign proc_go  = s1_valid_r && out_free;
  assign in_ch.ready = in_ready;

  // Decode one byte against the parse state
  always_comb begin
    logic       ctl;
    logic       done;
    logic       has;
    logic       merr;
    logic [6:0] len7;
    logic [3:0] lb_dec;
    logic [63:0] rem_sh;

    phase_nxt        = phase_r;
    fin_nxt          = fin_r;
    cur_op_nxt       = cur_op_r;
    len_left_nxt     = len_left_r;
    remain_nxt       = remain_r;
    first_op_nxt     = first_op_r;
    in_msg_nxt       = in_msg_r;
    should_close_nxt = should_close_r;
    emit             = 1'b0;
    done             = 1'b0;
    has              = 1'b0;
    merr             = 1'b0;
    len7             = s1_byte_r[6:0];
    lb_dec           = len_left_r - 4'd1;
    rem_sh           = {remain_r[55:0], s1_byte_r};
    ctl              = fin_r && cur_op_r[3];
    res_nxt          = '0;

    case (phase_r)
      wsfr_pkg::PH_HDR0: begin
        fin_nxt    = s1_byte_r[7];
        cur_op_nxt = s1_byte_r[3:0];
        if (!(s1_byte_r[7] && s1_byte_r[3]) && !in_msg_r) begin
          first_op_nxt = s1_byte_r[3:0];
          in_msg_nxt   = 1'b1;
        end
        phase_nxt = wsfr_pkg::PH_HDR1;
      end
      wsfr_pkg::PH_HDR1: begin
        if (s1_byte_r[7]) begin
          should_close_nxt = 1'b1;
          phase_nxt        = wsfr_pkg::PH_DISCARD;
          emit             = 1'b1;
          merr             = 1'b1;
        end else if (len7 == wsfr_pkg::LEN_EXT16 || len7 == wsfr_pkg::LEN_EXT64) begin
          len_left_nxt = (len7 == wsfr_pkg::LEN_EXT16) ? wsfr_pkg::EXT16_BYTES
                                                       : wsfr_pkg::EXT64_BYTES;
          remain_nxt   = '0;
          phase_nxt    = wsfr_pkg::PH_EXTLEN;
        end else begin
          remain_nxt = {57'd0, len7};
          if (len7 == 7'd0) begin
            emit = 1'b1;
            done = 1'b1;
          end else begin
            phase_nxt = wsfr_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfr_pkg::PH_EXTLEN: begin
        remain_nxt   = rem_sh;
        len_left_nxt = lb_dec;
        if (lb_dec == 4'd0) begin
          if (rem_sh == 64'd0) begin
            emit = 1'b1;
            done = 1'b1;
          end else begin
            phase_nxt = wsfr_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfr_pkg::PH_PAYLOAD: begin
        remain_nxt = remain_r - 64'd1;
        emit       = 1'b1;
        has        = 1'b1;
        done       = (remain_r == 64'd1);
      end
      default: begin
        // Discard and unused codes: drop the byte
      end
    endcase

    // Frame and message completion
    if (done) begin
      if (ctl) begin
        if (cur_op_r == wsfr_pkg::OP_CLOSE) begin
          res_nxt.close_seen = 1'b1;
          should_close_nxt   = 1'b1;
        end
      end else if (fin_r) begin
        res_nxt.message_done = 1'b1;
        in_msg_nxt           = 1'b0;
      end
      phase_nxt = wsfr_pkg::PH_HDR0;
    end

    res_nxt.payload_byte = has ? s1_byte_r : 8'd0;
    res_nxt.has_byte     = has;
    res_nxt.frame_opcode = cur_op_r;
    res_nxt.msg_opcode   = (ctl && !in_msg_r) ? 4'd0 : first_op_r;
    res_nxt.is_control   = ctl;
    res_nxt.frame_done   = done;
    res_nxt.masked_error = merr;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= wsfr_pkg::PH_HDR0;
      fin_r          <= 1'b0;
      cur_op_r       <= 4'd0;
      len_left_r     <= 4'd0;
      remain_r       <= 64'd0;
      first_op_r     <= 4'd0;
      in_msg_r       <= 1'b0;
      should_close_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= proc_go && emit;
      end
      if (proc_go) begin
        phase_r        <= phase_nxt;
        fin_r          <= fin_nxt;
        cur_op_r       <= cur_op_nxt;
        len_left_r     <= len_left_nxt;
        remain_r       <= remain_nxt;
        first_op_r     <= first_op_nxt;
        in_msg_r       <= in_msg_nxt;
        should_close_r <= should_close_nxt;
      end
    end
  end

  // Payload registers: capture byte and result
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (proc_go && emit) begin
      out_data_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_data_r.payload_byte;
  assign out_ch.has_byte     = out_data_r.has_byte;
  assign out_ch.frame_opcode = out_data_r.frame_opcode;
  assign out_ch.msg_opcode   = out_data_r.msg_opcode;
  assign out_ch.is_control   = out_data_r.is_control;
  assign out_ch.frame_done   = out_data_r.frame_done;
  assign out_ch.message_done = out_data_r.message_done;
  assign out_ch.close_seen   = out_data_r.close_seen;
  assign out_ch.masked_error = out_data_r.masked_error;

  // Checks
  `WSFR_ASSERT_IMPLY(a_discard_closes, phase_r == wsfr_pkg::PH_DISCARD, should_close_r)
  `WSFR_ASSERT_NEXT(a_discard_sticks, phase_r == wsfr_pkg::PH_DISCARD,
                    phase_r == wsfr_pkg::PH_DISCARD)
  `WSFR_ASSERT_IMPLY(a_merr_clean, out_valid_r && out_data_r.masked_error,
                     !out_data_r.has_byte && !out_data_r.frame_done)
  `WSFR_ASSERT_IMPLY(a_msg_done_frame, out_valid_r && out_data_r.message_done,
                     out_data_r.frame_done && !out_data_r.is_control && !in_msg_r)
  `WSFR_ASSERT_IMPLY(a_no_out_in_discard, phase_r == wsfr_pkg::PH_DISCARD && proc_go,
                     !emit)

endmodule
